FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the chunked body decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge while reset is released.
`define HCBD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hcbd assertion failed");

// Check a property on the rising clock edge at all times, reset included.
`define HCBD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("hcbd assertion failed");

`endif

FILE: rtl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, byte codes and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  typedef enum logic [1:0] {
    ST_COMPLETE     = 2'd0,
    ST_BAD_SIZE     = 2'd1,
    ST_BAD_DATA_END = 2'd2,
    ST_EARLY_END    = 2'd3
  } status_e;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  localparam logic [2:0] TRL_NONE = 3'd0;
  localparam logic [2:0] TRL_CR   = 3'd1;
  localparam logic [2:0] TRL_CRLF = 3'd2;
  localparam logic [2:0] TRL_CR2  = 3'd3;
  localparam logic [2:0] TRL_END  = 3'd4;

  // {is_digit, value}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_white(input logic [7:0] b);
    return (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
  endfunction

endpackage

FILE: rtl/hcbd_in_if.sv
// ----------------------------------------------------------------------------
// hcbd_in_if
// Raw body byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;
  logic       last;

  modport source (output valid, output data_byte, output first, output last, input ready);
  modport sink   (input valid, input data_byte, input first, input last, output ready);
endinterface

FILE: rtl/hcbd_out_if.sv
// ----------------------------------------------------------------------------
// hcbd_out_if
// Decoded result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hcbd_out_if;
  logic              valid;
  logic              ready;
  logic              out_valid;
  logic [7:0]        out_byte;
  logic              done_res;
  hcbd_pkg::status_e status;

  modport source (output valid, output out_valid, output out_byte, output done_res,
                  output status, input ready);
  modport sink   (input valid, input out_valid, input out_byte, input done_res,
                  input status, output ready);
endinterface

FILE: rtl/http_chunked_body_decoder_core.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// HTTP/1.1 chunked body decoder: one raw byte in, one result out per transfer.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload                                   | Handshake
// in_i    | in  | data_byte[7:0], first, last               | valid/ready
// out_o   | out | out_valid, out_byte[7:0], done_res, status | valid/ready
//
// One byte per cycle sustained while out_o.ready holds; each byte passes the
// input register, then parse logic into the result register.
// Reset (rst_ni, async) clears the handshake and parser state.
// in_i.ready drops only while both the input and result registers are full
// and the result is not being taken.
`include "assert_macros.svh"

module http_chunked_body_decoder_core #(
  parameter int SIZE_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hcbd_in_if.sink    in_i,
  hcbd_out_if.source out_o
);
  import hcbd_pkg::*;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_EXT     = 3'd1,
    PH_DATA    = 3'd2,
    PH_DATA_CR = 3'd3,
    PH_DATA_LF = 3'd4,
    PH_TRAILER = 3'd5,
    PH_DONE    = 3'd6
  } phase_e;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       done_res;
    status_e    status;
  } result_t;

  logic                  in_vld_q;
  logic [7:0]            byte_q;
  logic                  first_q;
  logic                  last_q;
  logic                  out_vld_q;
  result_t               res_q;
  result_t               res_d;
  logic                  out_load;

  phase_e                phase_q,   phase_d;
  logic [SIZE_WIDTH-1:0] size_q,    size_d;
  logic                  digits_q,  digits_d;
  logic                  space_q,   space_d;
  logic                  pcr_q,     pcr_d;
  logic [2:0]            trl_q,     trl_d;
  status_e               code_q,    code_d;

  assign out_load = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || out_load;

  always_comb begin
    logic [4:0] hv;
    hv        = hex_value(byte_q);
    phase_d   = phase_q;
    size_d    = size_q;
    digits_d  = digits_q;
    space_d   = space_q;
    pcr_d     = pcr_q;
    trl_d     = trl_q;
    code_d    = code_q;
    res_d     = '0;

    if (first_q) begin
      phase_d  = PH_SIZE;
      size_d   = '0;
      digits_d = 1'b0;
      space_d  = 1'b0;
      pcr_d    = 1'b0;
      trl_d    = TRL_CRLF;
      code_d   = ST_COMPLETE;
    end

    unique case (phase_d)
      PH_SIZE, PH_EXT: begin
        if (byte_q == CH_LF && pcr_d) begin
          pcr_d   = 1'b0;
          space_d = 1'b0;
          if (!digits_d) begin
            phase_d = PH_SIZE;
          end else begin
            digits_d = 1'b0;
            if (size_d == '0) begin
              phase_d = PH_TRAILER;
              trl_d   = TRL_CRLF;
            end else begin
              phase_d = PH_DATA;
            end
          end
        end else begin
          if (pcr_d) begin
            pcr_d = 1'b0;
            if (phase_d == PH_SIZE && digits_d) space_d = 1'b1;
          end
          if (byte_q == CH_CR) begin
            pcr_d = 1'b1;
          end else if (is_white(byte_q)) begin
            if (phase_d == PH_SIZE && digits_d) space_d = 1'b1;
          end else if (phase_d == PH_SIZE) begin
            if (hv[4]) begin
              if (space_d || size_d[SIZE_WIDTH-1 -: 4] != 4'd0) begin
                phase_d = PH_DONE;
                code_d  = ST_BAD_SIZE;
              end else begin
                size_d   = {size_d[SIZE_WIDTH-5:0], hv[3:0]};
                digits_d = 1'b1;
              end
            end else if (byte_q == CH_SEMI && digits_d) begin
              phase_d = PH_EXT;
            end else begin
              phase_d = PH_DONE;
              code_d  = ST_BAD_SIZE;
            end
          end
        end
      end
      PH_DATA: begin
        res_d.out_valid = 1'b1;
        res_d.out_byte  = byte_q;
        size_d          = size_d - SIZE_WIDTH'(1);
        if (size_d == '0) phase_d = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        if (byte_q == CH_CR) begin
          phase_d = PH_DATA_LF;
        end else begin
          phase_d = PH_DONE;
          code_d  = ST_BAD_DATA_END;
        end
      end
      PH_DATA_LF: begin
        if (byte_q == CH_LF) begin
          phase_d = PH_SIZE;
        end else begin
          phase_d = PH_DONE;
          code_d  = ST_BAD_DATA_END;
        end
      end
      PH_TRAILER: begin
        if (byte_q == CH_CR) begin
          trl_d = (trl_d == TRL_CRLF) ? TRL_CR2 : TRL_CR;
        end else if (byte_q == CH_LF) begin
          trl_d = (trl_d == TRL_CR) ? TRL_CRLF : (trl_d == TRL_CR2) ? TRL_END : TRL_NONE;
        end else begin
          trl_d = TRL_NONE;
        end
        if (trl_d == TRL_END) begin
          phase_d = PH_DONE;
          code_d  = ST_COMPLETE;
        end
      end
      default: begin
      end
    endcase

    if (last_q && phase_d != PH_DONE) begin
      phase_d = PH_DONE;
      code_d  = ST_EARLY_END;
    end

    res_d.done_res = (phase_d == PH_DONE);
    res_d.status   = (phase_d == PH_DONE) ? code_d : ST_COMPLETE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= PH_SIZE;
      size_q    <= '0;
      digits_q  <= 1'b0;
      space_q   <= 1'b0;
      pcr_q     <= 1'b0;
      trl_q     <= TRL_CRLF;
      code_q    <= ST_COMPLETE;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
        phase_q   <= phase_d;
        size_q    <= size_d;
        digits_q  <= digits_d;
        space_q   <= space_d;
        pcr_q     <= pcr_d;
        trl_q     <= trl_d;
        code_q    <= code_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q  <= in_i.data_byte;
      first_q <= in_i.first;
      last_q  <= in_i.last;
    end
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.out_valid = res_q.out_valid;
  assign out_o.out_byte  = res_q.out_byte;
  assign out_o.done_res  = res_q.done_res;
  assign out_o.status    = res_q.status;

  `HCBD_ASSERT(a_status_needs_done, clk_i, rst_ni, out_o.valid && !out_o.done_res |-> out_o.status == ST_COMPLETE)
  `HCBD_ASSERT(a_data_count_live, clk_i, rst_ni, phase_q == PH_DATA |-> size_q != '0)
  `HCBD_ASSERT(a_held_item_kept, clk_i, rst_ni, in_vld_q && !out_load |=> in_vld_q && $stable(byte_q))

endmodule
